// ===== design/frrq_pkg.sv =====
// shared types and codes for the fixed priority round robin ready queue
`timescale 1ns / 1ps
package frrq_pkg;

    localparam logic [2:0] OP_SCHEDULE = 3'd0;
    localparam logic [2:0] OP_WAKEUP   = 3'd1;
    localparam logic [2:0] OP_BLOCK    = 3'd2;
    localparam logic [2:0] OP_YIELD    = 3'd3;
    localparam logic [2:0] OP_SETPRIO  = 3'd4;
    localparam logic [2:0] OP_CREATE   = 3'd5;
    localparam logic [2:0] OP_DELETE   = 3'd6;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] thread_id;
        logic [7:0] new_priority;
    } t_in_item;

    typedef struct packed {
        logic [5:0] chosen_thread;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_SCH  = 11'b000_0000_0100,
        S_SCH2 = 11'b000_0000_1000,
        S_RD   = 11'b000_0001_0000,
        S_LV   = 11'b000_0010_0000,
        S_UNL  = 11'b000_0100_0000,
        S_AP0  = 11'b000_1000_0000,
        S_AP1  = 11'b001_0000_0000,
        S_AP2  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

endpackage

// ===== design/frrq_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module frrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/fixed_priority_round_robin_ready_queue.sv =====
// top level of the fixed priority round robin ready queue
`timescale 1ns / 1ps
// usage
//   input channel: i_valid / o_stall carry i_data (op, thread_id, new_priority);
//   a transfer happens at a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall carry o_data (chosen_thread, status),
//   exactly one result per input item, in order
// sequencing
//   items are handled one at a time; each walks a chain of registered reads
//   of the thread and link rams (read level, then head/tail, then write
//   back), with the append needing a second tail read and two writes to the
//   next-link ram; schedule reads the level heads instead, a wakeup of a
//   queued thread ends after the level read, and an unknown op or out of
//   range thread goes straight to the result
// reset
//   i_rst_n low clears the sequencer and the per-level non-empty bits; after
//   release the thread ram is swept, one entry a cycle, setting every thread
//   to the lowest level and not queued; o_stall stays high during the sweep
// stalls
//   the result sits in an output register; the next item is accepted while it
//   waits, and its own result is held back until the register frees up
module fixed_priority_round_robin_ready_queue #(
    parameter int NUM_THREADS = 64,
    parameter int NUM_LEVELS  = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  frrq_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output frrq_pkg::t_out_item o_data
);
    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int XW = (TW > 6) ? TW : 6;
    localparam logic [LW-1:0] LMAX = LW'(NUM_LEVELS - 1);
    localparam logic [TW-1:0] TLAST = TW'(NUM_THREADS - 1);

    // sequencer state and captured item
    frrq_pkg::t_state r_state, n_state;
    logic [TW-1:0]    r_clr, n_clr;
    logic [2:0]       r_op, n_op;
    logic [TW-1:0]    r_tid, n_tid;
    logic [LW-1:0]    r_np, n_np;
    logic [LW-1:0]    r_lv, n_lv;
    logic             r_q, n_q;
    logic [TW-1:0]    r_p, n_p;
    logic [TW-1:0]    r_n, n_n;
    logic             r_found, n_found;
    logic [1:0]       r_st, n_st;
    logic [5:0]       r_ch, n_ch;
    logic             r_ov, n_ov;
    frrq_pkg::t_out_item r_out, n_out;
    logic [NUM_LEVELS-1:0] r_ne, n_ne;

    // ram ports
    logic          tst_we;
    logic [TW-1:0] tst_wa;
    logic [LW:0]   tst_wd, tst_rd;
    logic          nxt_we, prv_we, hd_we, tl_we;
    logic [TW-1:0] nxt_wa, nxt_wd, nxt_rd, prv_wa, prv_wd, prv_rd;
    logic [LW-1:0] hd_wa, hd_ra, tl_wa, tl_ra;
    logic [TW-1:0] hd_wd, hd_rd, tl_wd, tl_rd;

    // input field conversion
    logic [XW-1:0] in_tid_x;
    logic [TW-1:0] in_tid;
    logic          in_tid_ok;
    logic [7:0]    in_np_sat;
    logic [XW-1:0] head_x;
    logic [LW-1:0] enc;
    logic          enc_any;
    logic [LW-1:0] tst_lv;

    assign in_tid_x  = XW'(i_data.thread_id);
    assign in_tid    = in_tid_x[TW-1:0];
    assign in_tid_ok = 11'(i_data.thread_id) < 11'(NUM_THREADS);
    assign in_np_sat = (9'(i_data.new_priority) >= 9'(NUM_LEVELS)) ?
                       8'(NUM_LEVELS - 1) : i_data.new_priority;
    assign head_x    = XW'(hd_rd);
    assign tst_lv    = tst_rd[LW-1:0];

    // highest non-empty level, lowest index wins
    always_comb begin
        enc     = '0;
        enc_any = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_ne[i]) begin
                enc     = LW'(i);
                enc_any = 1'b1;
            end
        end
    end

    assign o_stall = (r_state != frrq_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_op    = r_op;
        n_tid   = r_tid;
        n_np    = r_np;
        n_lv    = r_lv;
        n_q     = r_q;
        n_p     = r_p;
        n_n     = r_n;
        n_found = r_found;
        n_st    = r_st;
        n_ch    = r_ch;
        n_ov    = r_ov && i_stall;
        n_out   = r_out;
        n_ne    = r_ne;

        tst_we = 1'b0;
        tst_wa = r_tid;
        tst_wd = {1'b0, r_lv};
        nxt_we = 1'b0;
        nxt_wa = r_tid;
        nxt_wd = r_tid;
        prv_we = 1'b0;
        prv_wa = r_tid;
        prv_wd = r_tid;
        hd_we  = 1'b0;
        hd_wa  = r_lv;
        hd_wd  = r_tid;
        tl_we  = 1'b0;
        tl_wa  = r_lv;
        tl_wd  = r_tid;
        hd_ra  = (r_state == frrq_pkg::S_SCH) ? enc : tst_lv;
        tl_ra  = (r_state == frrq_pkg::S_AP0) ? r_lv : tst_lv;

        case (r_state)
            frrq_pkg::S_CLR: begin
                // sweep thread ram to lowest level, not queued
                tst_we = 1'b1;
                tst_wa = r_clr;
                tst_wd = {1'b0, LMAX};
                n_clr  = r_clr + 1'b1;
                if (r_clr == TLAST) begin
                    n_state = frrq_pkg::S_IDLE;
                end
            end
            frrq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op  = i_data.op;
                    n_tid = in_tid;
                    n_np  = in_np_sat[LW-1:0];
                    n_st  = frrq_pkg::ST_OK;
                    n_ch  = '0;
                    if (i_data.op == frrq_pkg::OP_SCHEDULE) begin
                        n_state = frrq_pkg::S_SCH;
                    end else if (!in_tid_ok || i_data.op == frrq_pkg::OP_UNUSED) begin
                        n_state = frrq_pkg::S_DONE;
                    end else begin
                        n_state = frrq_pkg::S_RD;
                    end
                end
            end
            frrq_pkg::S_SCH: begin
                n_found = enc_any;
                n_state = frrq_pkg::S_SCH2;
            end
            frrq_pkg::S_SCH2: begin
                n_ch    = r_found ? head_x[5:0] : 6'd0;
                n_st    = r_found ? frrq_pkg::ST_OK : frrq_pkg::ST_NONE;
                n_state = frrq_pkg::S_DONE;
            end
            frrq_pkg::S_RD: begin
                n_state = frrq_pkg::S_LV;
            end
            frrq_pkg::S_LV: begin
                // thread entry and links back; head and tail reads go out
                n_lv = tst_lv;
                n_q  = tst_rd[LW];
                n_p  = prv_rd;
                n_n  = nxt_rd;
                if (r_op == frrq_pkg::OP_WAKEUP) begin
                    if (tst_rd[LW]) begin
                        n_st    = frrq_pkg::ST_QUEUED;
                        n_state = frrq_pkg::S_DONE;
                    end else begin
                        n_state = frrq_pkg::S_AP0;
                    end
                end else begin
                    n_state = frrq_pkg::S_UNL;
                end
            end
            frrq_pkg::S_UNL: begin
                if (r_q) begin
                    if (hd_rd == r_tid && tl_rd == r_tid) begin
                        n_ne[r_lv] = 1'b0;
                    end else if (hd_rd == r_tid) begin
                        hd_we = 1'b1;
                        hd_wd = r_n;
                    end else if (tl_rd == r_tid) begin
                        tl_we = 1'b1;
                        tl_wd = r_p;
                    end else begin
                        nxt_we = 1'b1;
                        nxt_wa = r_p;
                        nxt_wd = r_n;
                        prv_we = 1'b1;
                        prv_wa = r_n;
                        prv_wd = r_p;
                    end
                end
                if (r_op == frrq_pkg::OP_SETPRIO) begin
                    n_lv = r_np;
                end else if (r_op == frrq_pkg::OP_CREATE) begin
                    n_lv = LMAX;
                end
                tst_we = 1'b1;
                tst_wd = {1'b0, n_lv};
                if (r_op == frrq_pkg::OP_YIELD || r_op == frrq_pkg::OP_SETPRIO) begin
                    n_state = frrq_pkg::S_AP0;
                end else begin
                    n_state = frrq_pkg::S_DONE;
                end
            end
            frrq_pkg::S_AP0: begin
                n_state = frrq_pkg::S_AP1;
            end
            frrq_pkg::S_AP1: begin
                tst_we = 1'b1;
                tst_wd = {1'b1, r_lv};
                tl_we  = 1'b1;
                prv_we = 1'b1;
                if (r_ne[r_lv]) begin
                    nxt_we = 1'b1;
                    nxt_wa = tl_rd;
                    prv_wd = tl_rd;
                end else begin
                    hd_we      = 1'b1;
                    n_ne[r_lv] = 1'b1;
                end
                n_state = frrq_pkg::S_AP2;
            end
            frrq_pkg::S_AP2: begin
                // tail of the level links to itself
                nxt_we  = 1'b1;
                n_state = frrq_pkg::S_DONE;
            end
            frrq_pkg::S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov                = 1'b1;
                    n_out.chosen_thread = r_ch;
                    n_out.status        = r_st;
                    n_state             = frrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frrq_pkg::S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_ne    <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_ne    <= n_ne;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_tid   <= n_tid;
        r_np    <= n_np;
        r_lv    <= n_lv;
        r_q     <= n_q;
        r_p     <= n_p;
        r_n     <= n_n;
        r_found <= n_found;
        r_st    <= n_st;
        r_ch    <= n_ch;
        r_out   <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    // queued mark and level per thread
    frrq_ram #(.WIDTH(LW + 1), .DEPTH(NUM_THREADS)) u_tst (
        .i_clk(i_clk), .i_we(tst_we), .i_waddr(tst_wa), .i_wdata(tst_wd),
        .i_raddr(r_tid), .o_rdata(tst_rd)
    );

    frrq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(r_tid), .o_rdata(nxt_rd)
    );

    frrq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(r_tid), .o_rdata(prv_rd)
    );

    frrq_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd)
    );

    frrq_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_rd)
    );

    // checks
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == frrq_pkg::ST_NONE) |-> (o_data.chosen_thread == 6'd0))
        else $error("no-thread result carries a thread number");

    a_sched_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frrq_pkg::S_SCH && !(|r_ne)) |=> ##1 (r_st == frrq_pkg::ST_NONE))
        else $error("schedule over empty levels did not report none");

    a_append_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frrq_pkg::S_AP1) |=> r_ne[$past(r_lv)])
        else $error("append left its level marked empty");
endmodule
